[hdl/assert_macros.svh]
// Assertion macros shared by the RTL of the PID block.
// Depends on nothing; assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that prop holds at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Check that cond never holds at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[hdl/pwic_pkg.sv]
// Package of the PID block: widths, register codes, microcode word and program.
// Depends on nothing; used by pwic_seq and the top level.
package pwic_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int OUT_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int ACC_W       = 50;  // holds any rounded product and the sum of three
  localparam int RMAG_W      = ACC_W - 1;
  localparam int CFG_IDX_W   = 3;
  localparam int STEP_W      = 3;

  localparam logic [ACC_W-1:0] DRIVE_MAX =
    {{(ACC_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [ACC_W-1:0] DRIVE_MIN = ~DRIVE_MAX;
  localparam logic [ACC_W-1:0] WORD_MAX  = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
  localparam logic [ACC_W-1:0] WORD_MIN  = ~WORD_MAX;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_PERIOD = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_UPPER    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LOWER    = 3'd6;

  localparam logic [31:0] RST_SAMPLE_PERIOD  = 32'd214748;
  localparam logic [31:0] RST_INVERSE_PERIOD = 32'd1310720000;
  localparam logic [31:0] RST_INTEG_UPPER    = 32'd6553600;
  localparam logic [31:0] RST_INTEG_LOWER    = 32'hFF9C_0000;

  // Multiplier operand pairs
  localparam logic [2:0] MUL_NONE     = 3'd0;
  localparam logic [2:0] MUL_E_TS     = 3'd1;
  localparam logic [2:0] MUL_DIFF_INV = 3'd2;
  localparam logic [2:0] MUL_KP_E     = 3'd3;
  localparam logic [2:0] MUL_KI_INT   = 3'd4;
  localparam logic [2:0] MUL_KD_DER   = 3'd5;

  // Destinations of the rounded product
  localparam logic [2:0] DST_NONE    = 3'd0;
  localparam logic [2:0] DST_INTEG   = 3'd1;
  localparam logic [2:0] DST_DERIV   = 3'd2;
  localparam logic [2:0] DST_SUM_LD  = 3'd3;
  localparam logic [2:0] DST_SUM_ADD = 3'd4;

  // Step conditions
  localparam logic [1:0] COND_NONE = 2'd0;
  localparam logic [1:0] COND_IN   = 2'd1;  // hold until an item is accepted
  localparam logic [1:0] COND_OUT  = 2'd2;  // hold while the result register is full and not drained

  typedef struct packed {
    logic [2:0]        mul_sel;
    logic [2:0]        rnd_dst;
    logic              shift_hi;  // round at bit 32 instead of bit 16
    logic [1:0]        cond;
    logic [STEP_W-1:0] next;
  } ctrl_word_t;

  typedef struct packed {
    logic in_go;     // input item present
    logic out_busy;  // result register full and not drained this cycle
  } seq_status_t;

  // Microcode: each step may start one product and retire the previous one.
  function automatic ctrl_word_t micro_rom(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    case (step)
      3'd0:    w = '{MUL_NONE,     DST_NONE,    1'b0, COND_IN,   3'd1};
      3'd1:    w = '{MUL_E_TS,     DST_NONE,    1'b0, COND_NONE, 3'd2};
      3'd2:    w = '{MUL_DIFF_INV, DST_INTEG,   1'b1, COND_NONE, 3'd3};
      3'd3:    w = '{MUL_KP_E,     DST_DERIV,   1'b0, COND_NONE, 3'd4};
      3'd4:    w = '{MUL_KI_INT,   DST_SUM_LD,  1'b0, COND_NONE, 3'd5};
      3'd5:    w = '{MUL_KD_DER,   DST_SUM_ADD, 1'b0, COND_NONE, 3'd6};
      3'd6:    w = '{MUL_NONE,     DST_SUM_ADD, 1'b0, COND_NONE, 3'd7};
      3'd7:    w = '{MUL_NONE,     DST_NONE,    1'b0, COND_OUT,  3'd0};
      default: w = '{MUL_NONE,     DST_NONE,    1'b0, COND_IN,   3'd0};
    endcase
    return w;
  endfunction

endpackage

[hdl/pid_with_integrator_clamp_unit.sv]
// Top level of the PID controller with clamped integrator.
// Depends on pwic_pkg, pwic_seq and assert_macros.svh.
//
//  channel  direction  handshake                  payload
//  in_      slave      in_tvalid / in_tready      in_tdata[31:0]  error_sample
//  out_     master     out_tvalid / out_tready    out_tdata[31:0] drive
//  cfg_     slave      cfg_valid / cfg_ready      cfg_index, cfg_data
//
// An item runs through the program steps from acceptance to a valid result; five
// products share one 32x32 multiplier, so no new item enters until the last is done.
// rst_n is synchronous: it clears the integral, the previous error, out_tvalid and
// the step counter, and returns the configuration registers to their reset values.
// A full, stalled result register holds the last step; no item is taken until the
// program returns to its first step. cfg_ready is always high.
module pid_with_integrator_clamp_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [31:0]                       in_tdata,   // [31:0] error_sample
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pwic_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [DATA_WIDTH-1:0] drive
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pwic_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_data
);
  import pwic_pkg::*;

  // Configuration registers
  logic [31:0] kp_r, ki_r, kd_r, ts_r, inv_r, hi_r, lo_r;

  // Datapath state
  logic [31:0]           err_r;     // current error sample
  logic [31:0]           prev_r;    // previous error sample
  logic [31:0]           integ_r;   // integral accumulator
  logic [31:0]           deriv_r;   // saturated derivative
  logic [63:0]           prod_r;    // product magnitude
  logic                  neg_r;     // product sign
  logic [ACC_W-1:0]      sum_r;     // drive accumulator
  logic [DATA_WIDTH-1:0] drive_r;
  logic                  out_valid_r;

  ctrl_word_t  ctrl;
  seq_status_t status;
  logic        accept, finish;

  // Sequencer
  assign in_tready       = (ctrl.cond == COND_IN);
  assign accept          = in_tvalid & in_tready;
  assign status.in_go    = in_tvalid;
  assign status.out_busy = out_valid_r & ~out_tready;
  assign finish          = (ctrl.cond == COND_OUT) & ~status.out_busy;

  pwic_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  // Configuration port: always ready, unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r  <= '0;
      ki_r  <= '0;
      kd_r  <= '0;
      ts_r  <= RST_SAMPLE_PERIOD;
      inv_r <= RST_INVERSE_PERIOD;
      hi_r  <= RST_INTEG_UPPER;
      lo_r  <= RST_INTEG_LOWER;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PROP_GAIN:      kp_r  <= cfg_data;
        REG_INTEG_GAIN:     ki_r  <= cfg_data;
        REG_DERIV_GAIN:     kd_r  <= cfg_data;
        REG_SAMPLE_PERIOD:  ts_r  <= cfg_data;
        REG_INVERSE_PERIOD: inv_r <= cfg_data;
        REG_INTEG_UPPER:    hi_r  <= cfg_data;
        REG_INTEG_LOWER:    lo_r  <= cfg_data;
        default:            ;
      endcase
    end
  end

  // Magnitude of a signed 32-bit word; the most negative value maps to 2^31
  function automatic logic [31:0] mag32(input logic [31:0] x);
    return x[31] ? (32'd0 - x) : x;
  endfunction

  // Operand selection for the shared multiplier
  logic [32:0] diff;
  logic [32:0] diff_mag;
  logic [31:0] mul_a, mul_b;
  logic        mul_neg;
  logic [63:0] mul_p;

  assign diff     = {err_r[31], err_r} - {prev_r[31], prev_r};
  // |diff| never exceeds 2^32-1, so the low 32 bits carry it
  assign diff_mag = diff[32] ? (33'd0 - diff) : diff;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (ctrl.mul_sel)
      MUL_E_TS: begin
        mul_a   = mag32(err_r);
        mul_b   = ts_r;
        mul_neg = err_r[31];
      end
      MUL_DIFF_INV: begin
        mul_a   = diff_mag[31:0];
        mul_b   = inv_r;
        mul_neg = diff[32];
      end
      MUL_KP_E: begin
        mul_a   = mag32(kp_r);
        mul_b   = mag32(err_r);
        mul_neg = kp_r[31] ^ err_r[31];
      end
      MUL_KI_INT: begin
        mul_a   = mag32(ki_r);
        mul_b   = mag32(integ_r);
        mul_neg = ki_r[31] ^ integ_r[31];
      end
      MUL_KD_DER: begin
        mul_a   = mag32(kd_r);
        mul_b   = mag32(deriv_r);
        mul_neg = kd_r[31] ^ deriv_r[31];
      end
      default: begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Round the held product to nearest, ties away from zero, then apply the sign
  logic [RMAG_W-1:0] rnd_mag;
  logic [ACC_W-1:0]  rnd_val;

  always_comb begin
    if (ctrl.shift_hi) begin
      rnd_mag = RMAG_W'(prod_r[63:32]) + RMAG_W'(prod_r[31]);
    end else begin
      rnd_mag = RMAG_W'(prod_r[63:16]) + RMAG_W'(prod_r[15]);
    end
    rnd_val = neg_r ? (ACC_W'(0) - {1'b0, rnd_mag}) : {1'b0, rnd_mag};
  end

  // Integral update with clamp: upper test first, so it wins on crossed limits
  logic [ACC_W-1:0] integ_sum, hi_ext, lo_ext;
  logic [31:0]      integ_clamped;
  logic [31:0]      deriv_sat;
  logic [ACC_W-1:0] sum_add;
  logic [ACC_W-1:0] drive_sat;

  assign integ_sum = {{(ACC_W-32){integ_r[31]}}, integ_r} + rnd_val;
  assign hi_ext    = {{(ACC_W-32){hi_r[31]}}, hi_r};
  assign lo_ext    = {{(ACC_W-32){lo_r[31]}}, lo_r};
  assign sum_add   = sum_r + rnd_val;

  always_comb begin
    if ($signed(integ_sum) > $signed(hi_ext)) begin
      integ_clamped = hi_r;
    end else if ($signed(integ_sum) < $signed(lo_ext)) begin
      integ_clamped = lo_r;
    end else begin
      integ_clamped = integ_sum[31:0];
    end

    if ($signed(rnd_val) > $signed(WORD_MAX)) begin
      deriv_sat = WORD_MAX[31:0];
    end else if ($signed(rnd_val) < $signed(WORD_MIN)) begin
      deriv_sat = WORD_MIN[31:0];
    end else begin
      deriv_sat = rnd_val[31:0];
    end

    if ($signed(sum_r) > $signed(DRIVE_MAX)) begin
      drive_sat = DRIVE_MAX;
    end else if ($signed(sum_r) < $signed(DRIVE_MIN)) begin
      drive_sat = DRIVE_MIN;
    end else begin
      drive_sat = sum_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      err_r <= in_tdata;
    end
    if (ctrl.mul_sel != MUL_NONE) begin
      prod_r <= mul_p;
      neg_r  <= mul_neg;
    end
    case (ctrl.rnd_dst)
      DST_DERIV:   deriv_r <= deriv_sat;
      DST_SUM_LD:  sum_r   <= rnd_val;
      DST_SUM_ADD: sum_r   <= sum_add;
      default:     ;
    endcase
    if (finish) begin
      drive_r <= drive_sat[DATA_WIDTH-1:0];
    end
  end

  // Controller state and result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_r     <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.rnd_dst == DST_INTEG) begin
        integ_r <= integ_clamped;
      end
      if (finish) begin
        prev_r      <= err_r;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(drive_r);

  // Assertions
`include "assert_macros.svh"

  // A result appears only from the last program step
  `ASSERT_CLK(a_out_from_finish, clk, rst_n,
    $rose(out_valid_r) |-> $past(ctrl.cond == COND_OUT))
  // With ordered limits the clamped integral lies between them
  `ASSERT_CLK(a_integ_in_range, clk, rst_n,
    ($past(ctrl.rnd_dst == DST_INTEG) && ($signed($past(lo_r)) <= $signed($past(hi_r))))
      |-> (($signed(integ_r) <= $signed($past(hi_r)))
        && ($signed(integ_r) >= $signed($past(lo_r)))))
  // The previous error changes only when a result is produced
  `ASSERT_NEVER(a_prev_only_at_finish, clk, rst_n,
    !$stable(prev_r) && !$past(finish))

endmodule

[hdl/pwic_seq.sv]
// Microcode sequencer of the PID block: step counter, program table, jumps.
// Depends on pwic_pkg.
module pwic_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pwic_pkg::seq_status_t status,
  output pwic_pkg::ctrl_word_t  ctrl
);
  import pwic_pkg::*;

  logic [STEP_W-1:0] step_r, step_nxt;

  assign ctrl = micro_rom(step_r);

  always_comb begin
    step_nxt = ctrl.next;
    case (ctrl.cond)
      COND_IN:   if (!status.in_go) step_nxt = step_r;
      COND_OUT:  if (status.out_busy) step_nxt = step_r;
      default:   step_nxt = ctrl.next;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule
